[sv/wcpm_pkg.sv]
// ----------------------------------------------------------------------------
// wcpm_pkg: shared types and constants for the WAV chunk parser and mixdown
// Holds the in/out payload structs, chunk ids and the front-to-back job record.
// ----------------------------------------------------------------------------
`default_nettype none
package wcpm_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [15:0] dac_sample;
		logic [1:0]  status;
	} out_item_t;

	localparam logic [31:0] ID_RIFF = 32'h46464952;
	localparam logic [31:0] ID_FMT  = 32'h20746d66;
	localparam logic [31:0] ID_DATA = 32'h61746164;
	localparam logic [31:0] ID_LIST = 32'h5453494c;

	localparam logic [1:0] ST_SAMPLE = 2'd0;
	localparam logic [1:0] ST_EARLY  = 2'd1;
	localparam logic [1:0] ST_BADCH  = 2'd2;

	localparam logic [1:0] WK_NONE = 2'd0;
	localparam logic [1:0] WK_B8   = 2'd1;
	localparam logic [1:0] WK_B16  = 2'd2;
	localparam logic [1:0] WK_B32  = 2'd3;

	// One finished slice handed from the parser to the mixer
	typedef struct packed {
		logic        early;
		logic        bad_ch;
		logic [1:0]  kind;
		logic [35:0] sum;
		logic [15:0] chans;
	} job_t;

endpackage
`default_nettype wire

[sv/wav_chunk_parser_mixdown.sv]
// A closed slice is posted as a job; the mixer takes it only when idle with no result
// pending, divides in 36 steps and loads the sample; errors are loaded on taking.
// The parser takes one byte per cycle unless a finished slice is waiting.
// One finished slice waits in the parser while the mixer works; input then stalls.
// Reset (arst_n low) returns the parser to header search and clears all results.
// ----------------------------------------------------------------------------
// wav_chunk_parser_mixdown: RIFF/WAVE byte parser with channel mixdown
// Parser front end posts slices; mixer back end averages and scales them.
// ----------------------------------------------------------------------------
`default_nettype none
module wav_chunk_parser_mixdown #(
	parameter int MAX_CHANNELS = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wcpm_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  wire                  out_ready,
	output wcpm_pkg::out_item_t  out_data
);
	import wcpm_pkg::*;

	logic job_valid, job_ready;
	job_t job;

	wcpm_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.job_valid, .job_ready, .job
	);

	wcpm_back u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job,
		.out_valid, .out_ready, .out_data
	);
endmodule
`default_nettype wire

[sv/wcpm_front.sv]
// ----------------------------------------------------------------------------
// wcpm_front: chunk parser and channel accumulator
// Consumes one byte per transfer, tracks chunk state and posts slice jobs.
// ----------------------------------------------------------------------------
`default_nettype none
module wcpm_front #(
	parameter int MAX_CHANNELS = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wcpm_pkg::in_item_t   in_data,
	output logic                 job_valid,
	input  wire                  job_ready,
	output wcpm_pkg::job_t       job
);
	import wcpm_pkg::*;

	typedef enum logic [2:0] {PH_HEADER, PH_RIFF, PH_FMT, PH_SKIP, PH_DATA} phase_t;

	phase_t       phase_q;
	logic [63:0]  hdr_q;
	logic [4:0]   fcnt_q;
	logic [31:0]  left_q;
	logic [15:0]  chans_q, balign_q, bits_q, sidx_q;
	logic [31:0]  asm_q;
	logic [35:0]  sum_q;

	// byte position and channel of the current byte inside the slice
	logic [1:0]   kind, pos, wlast;
	logic [15:0]  ch;
	logic [63:0]  hdr_n;
	logic [31:0]  id, sz, asm_n, left_dec;
	logic [35:0]  sval, sum_n;
	logic         add_en, slice_end, last, eos, fire, post;
	logic [15:0]  sidx_inc;
	job_t         job_n;

	assign eos = in_data.end_of_stream;
	// hold input while a finished slice waits for the mixer
	assign in_ready = !job_valid || job_ready;
	assign fire = in_valid && in_ready;

	always_comb begin
		unique case (bits_q)
			16'd8:   kind = WK_B8;
			16'd16:  kind = WK_B16;
			16'd32:  kind = WK_B32;
			default: kind = WK_NONE;
		endcase
	end

	always_comb begin
		unique case (kind)
			WK_B16:  begin pos = {1'b0, sidx_q[0]}; ch = {1'b0, sidx_q[15:1]}; wlast = 2'd1; end
			WK_B32:  begin pos = sidx_q[1:0]; ch = {2'b0, sidx_q[15:2]}; wlast = 2'd3; end
			default: begin pos = 2'd0; ch = sidx_q; wlast = 2'd0; end
		endcase
	end

	always_comb begin
		asm_n = (pos == 2'd0) ? {24'd0, in_data.data_byte}
			: (asm_q | ({24'd0, in_data.data_byte} << {pos, 3'b000}));
		unique case (kind)
			WK_B8:   sval = {28'd0, asm_n[7:0]};
			WK_B16:  sval = {{20{asm_n[15]}}, asm_n[15:0]};
			default: sval = {{4{asm_n[31]}}, asm_n};
		endcase
		add_en = (kind != WK_NONE) && (pos == wlast) && (ch < chans_q)
			&& (ch < 16'(MAX_CHANNELS));
		sum_n = add_en ? sum_q + sval : sum_q;
		hdr_n = {in_data.data_byte, hdr_q[63:8]};
		id = hdr_n[31:0];
		sz = hdr_n[63:32];
		left_dec = (left_q != 32'd0) ? left_q - 32'd1 : left_q;
		sidx_inc = sidx_q + 16'd1;
		slice_end = sidx_inc >= balign_q;
		last = left_dec < {16'd0, balign_q};
	end

	// build the job for a closed slice or an early end inside a data chunk
	always_comb begin
		post = (phase_q == PH_DATA) && (slice_end || eos);
		job_n.early = slice_end ? (eos && !last) : 1'b1;
		job_n.bad_ch = slice_end && (chans_q == 16'd0 || chans_q > 16'(MAX_CHANNELS));
		job_n.kind = kind;
		job_n.sum = slice_end ? sum_n : 36'd0;
		job_n.chans = chans_q;
	end

	// parse one byte per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER; hdr_q <= '0; fcnt_q <= '0; left_q <= '0;
			chans_q <= '0; balign_q <= '0; bits_q <= '0; sidx_q <= '0;
			asm_q <= '0; sum_q <= '0; job_valid <= 1'b0; job <= '0;
		end else begin
			// post a new job or retire the one taken by the mixer
			if (fire && post) begin
				job_valid <= 1'b1;
				job <= job_n;
			end else if (job_valid && job_ready) begin
				job_valid <= 1'b0;
			end
			if (fire) begin
				// end of file returns the parse state to its reset value
				if (eos) begin
					phase_q <= PH_HEADER; hdr_q <= '0; fcnt_q <= '0; left_q <= '0;
					chans_q <= '0; balign_q <= '0; bits_q <= '0; sidx_q <= '0;
					asm_q <= '0; sum_q <= '0;
				end else begin
					unique case (phase_q)
						PH_HEADER: begin
							hdr_q <= hdr_n;
							if (fcnt_q == 5'd7) begin
								fcnt_q <= '0;
								if (id == ID_RIFF) phase_q <= PH_RIFF;
								else if (id == ID_FMT) begin
									left_q <= sz; phase_q <= PH_FMT;
								end else if (id == ID_DATA && balign_q != 16'd0
									&& sz >= {16'd0, balign_q}) begin
									left_q <= sz; sidx_q <= '0; asm_q <= '0; sum_q <= '0;
									phase_q <= PH_DATA;
								end else begin
									left_q <= sz;
									phase_q <= (sz == 32'd0) ? PH_HEADER : PH_SKIP;
								end
							end else begin
								fcnt_q <= fcnt_q + 5'd1;
							end
						end
						PH_RIFF: begin
							if (fcnt_q == 5'd3) begin fcnt_q <= '0; phase_q <= PH_HEADER; end
							else fcnt_q <= fcnt_q + 5'd1;
						end
						PH_FMT: begin
							unique case (fcnt_q)
								5'd2:    chans_q[7:0]   <= in_data.data_byte;
								5'd3:    chans_q[15:8]  <= in_data.data_byte;
								5'd12:   balign_q[7:0]  <= in_data.data_byte;
								5'd13:   balign_q[15:8] <= in_data.data_byte;
								5'd14:   bits_q[7:0]    <= in_data.data_byte;
								5'd15:   bits_q[15:8]   <= in_data.data_byte;
								default: ;
							endcase
							if (fcnt_q == 5'd15) begin
								fcnt_q <= '0;
								left_q <= (left_q > 32'd16) ? left_q - 32'd16 : 32'd0;
								phase_q <= (left_q > 32'd16) ? PH_SKIP : PH_HEADER;
							end else begin
								fcnt_q <= fcnt_q + 5'd1;
							end
						end
						PH_SKIP: begin
							left_q <= left_dec;
							if (left_dec == 32'd0) phase_q <= PH_HEADER;
						end
						PH_DATA: begin
							left_q <= left_dec;
							if (slice_end) begin
								sidx_q <= '0; asm_q <= '0; sum_q <= '0;
								if (last) begin
									phase_q <= (left_dec == 32'd0) ? PH_HEADER : PH_SKIP;
								end
							end else begin
								sidx_q <= sidx_inc;
								if (kind != WK_NONE) asm_q <= asm_n;
								sum_q <= sum_n;
							end
						end
						default: phase_q <= PH_HEADER;
					endcase
				end
			end
		end
	end

	property p_ready_when_free;
		@(posedge clk) disable iff (!arst_n) !job_valid |-> in_ready;
	endproperty
	a_ready_when_free: assert property (p_ready_when_free) else $error("front stalled while empty");

	property p_job_hold;
		@(posedge clk) disable iff (!arst_n) job_valid && !job_ready |=> job_valid && $stable(job);
	endproperty
	a_job_hold: assert property (p_job_hold) else $error("job dropped");

	property p_eos_reset;
		@(posedge clk) disable iff (!arst_n) fire && eos |=> phase_q == PH_HEADER && sidx_q == 16'd0;
	endproperty
	a_eos_reset: assert property (p_eos_reset) else $error("no reset after end of stream");
endmodule
`default_nettype wire

[sv/wcpm_back.sv]
// ----------------------------------------------------------------------------
// wcpm_back: slice mixer
// Divides the channel sum by the channel count (restoring, one bit a cycle)
// and scales the quotient to a 16-bit DAC word.
// ----------------------------------------------------------------------------
`default_nettype none
module wcpm_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  job_valid,
	output logic                 job_ready,
	input  wcpm_pkg::job_t       job,
	output logic                 out_valid,
	input  wire                  out_ready,
	output wcpm_pkg::out_item_t  out_data
);
	import wcpm_pkg::*;

	typedef enum logic [1:0] {B_IDLE, B_DIV, B_OUT} bstate_t;

	bstate_t      st_q;
	logic [35:0]  quo_q;
	logic [35:0]  rem_q;
	logic [15:0]  den_q;
	logic [5:0]   cnt_q;
	logic         neg_q;
	logic [1:0]   kind_q;

	logic [36:0]  trial;
	logic [35:0]  rem_sh, avg;
	logic [15:0]  word;

	always_comb begin
		rem_sh = {rem_q[34:0], quo_q[35]};
		trial = {1'b0, rem_sh} - {21'd0, den_q};
		avg = neg_q ? (36'd0 - quo_q) : quo_q;
		unique case (kind_q)
			WK_B8:   word = {avg[7:0], 8'd0};
			WK_B16:  word = avg[15:0] + 16'h8000;
			WK_B32:  word = avg[31:16] + 16'h8000;
			default: word = 16'd0;
		endcase
	end

	assign job_ready = (st_q == B_IDLE) && !out_valid;

	// accept a job, divide unless it is an error, present the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE; out_valid <= 1'b0; out_data <= '0;
			quo_q <= '0; rem_q <= '0; den_q <= '0; cnt_q <= '0; neg_q <= 1'b0;
			kind_q <= WK_NONE;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (st_q)
				B_IDLE: if (job_valid && job_ready) begin
					if (job.early || job.bad_ch) begin
						out_valid <= 1'b1;
						out_data.dac_sample <= 16'd0;
						out_data.status <= job.early ? ST_EARLY : ST_BADCH;
					end else begin
						neg_q <= job.sum[35];
						quo_q <= job.sum[35] ? 36'd0 - job.sum : job.sum;
						rem_q <= '0; den_q <= job.chans; kind_q <= job.kind;
						cnt_q <= 6'd36; st_q <= B_DIV;
					end
				end
				B_DIV: begin
					if (!trial[36]) begin
						rem_q <= trial[35:0]; quo_q <= {quo_q[34:0], 1'b1};
					end else begin
						rem_q <= rem_sh; quo_q <= {quo_q[34:0], 1'b0};
					end
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) st_q <= B_OUT;
				end
				B_OUT: begin
					out_valid <= 1'b1;
					out_data.dac_sample <= word;
					out_data.status <= ST_SAMPLE;
					st_q <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	property p_hold;
		@(posedge clk) disable iff (!arst_n) out_valid && !out_ready |=> out_valid && $stable(out_data);
	endproperty
	a_hold: assert property (p_hold) else $error("result dropped");

	property p_zero_on_err;
		@(posedge clk) disable iff (!arst_n) out_valid && out_data.status != ST_SAMPLE
			|-> out_data.dac_sample == 16'd0;
	endproperty
	a_zero_on_err: assert property (p_zero_on_err) else $error("nonzero sample on error");

	property p_busy;
		@(posedge clk) disable iff (!arst_n) st_q == B_DIV |-> !job_ready;
	endproperty
	a_busy: assert property (p_busy) else $error("job taken mid divide");
endmodule
`default_nettype wire

[bench/wav_chunk_parser_mixdown_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wav_chunk_parser_mixdown_test: self-checking bench for the WAV mixdown block
// Feeds byte streams of RIFF/fmt/LIST/data chunks, predicts each DAC word or
// error status from its own parser model, and checks results in order.
// ----------------------------------------------------------------------------
`default_nettype none
module wav_chunk_parser_mixdown_test;
	import wcpm_pkg::*;

	localparam int MAX_CH = 8;
	localparam int CYCLE_LIMIT = 1500000;

	typedef enum logic [2:0] {P_HEADER, P_RIFF, P_FMT, P_SKIP, P_DATA} phase_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	wav_chunk_parser_mixdown #(.MAX_CHANNELS(MAX_CH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always #1 clk = ~clk;

	// predictor state
	phase_e             pm_phase;
	logic [63:0]        pm_hdr;
	int unsigned        pm_fcnt;
	logic [31:0]        pm_left;
	logic [15:0]        pm_chans, pm_align, pm_bits;
	int unsigned        pm_idx;
	logic [31:0]        pm_asm;
	longint             pm_sum;

	out_item_t mix_expected[$];
	int mismatches = 0;
	int cycles = 0;
	int burst_left = 0;
	int gap_left = 0;

	function automatic void clear_parser();
		pm_phase = P_HEADER; pm_hdr = '0; pm_fcnt = 0; pm_left = '0;
		pm_chans = '0; pm_align = '0; pm_bits = '0; pm_idx = 0;
		pm_asm = '0; pm_sum = 0;
	endfunction

	function automatic void start_skip(logic [31:0] n);
		pm_left = n;
		pm_phase = (n == 0) ? P_HEADER : P_SKIP;
	endfunction

	function automatic int unsigned sample_width();
		case (pm_bits)
			16'd8:   return 1;
			16'd16:  return 2;
			16'd32:  return 4;
			default: return 0;
		endcase
	endfunction

	// accumulate one sample byte into the slice sum
	function automatic void accumulate(logic [7:0] b);
		int unsigned w, pos, ch;
		w = sample_width();
		if (w == 0) return;
		pos = pm_idx % w;
		ch = pm_idx / w;
		if (pos == 0) pm_asm = {24'd0, b};
		else pm_asm = pm_asm | (32'(b) << (8 * pos));
		if (pos != w - 1 || ch >= pm_chans || ch >= MAX_CH) return;
		if (w == 1) pm_sum += longint'(pm_asm[7:0]);
		else if (w == 2) pm_sum += longint'($signed(pm_asm[15:0]));
		else pm_sum += longint'($signed(pm_asm));
	endfunction

	function automatic out_item_t mix_slice();
		out_item_t r;
		longint avg;
		r = '0;
		if (pm_chans == 0 || pm_chans > MAX_CH) begin
			r.status = ST_BADCH;
			return r;
		end
		avg = pm_sum / longint'(pm_chans);
		r.status = ST_SAMPLE;
		if (pm_bits == 16'd8) r.dac_sample = 16'(avg << 8);
		else if (pm_bits == 16'd16) r.dac_sample = 16'(avg + 32768);
		else if (pm_bits == 16'd32) r.dac_sample = 16'((avg >>> 16) + 32768);
		return r;
	endfunction

	// advance the predictor by one byte and queue any result
	function automatic void predict_byte(in_item_t it);
		logic [7:0] b;
		logic [31:0] id, size;
		out_item_t r;
		logic last;
		b = it.data_byte;
		r = '0;
		case (pm_phase)
			P_HEADER: begin
				pm_hdr = {b, pm_hdr[63:8]};
				pm_fcnt++;
				if (pm_fcnt >= 8) begin
					pm_fcnt = 0;
					id = pm_hdr[31:0];
					size = pm_hdr[63:32];
					if (id == ID_RIFF) pm_phase = P_RIFF;
					else if (id == ID_FMT) begin
						pm_left = size;
						pm_phase = P_FMT;
					end else if (id == ID_DATA) begin
						if (pm_align == 0 || size < pm_align) start_skip(size);
						else begin
							pm_left = size; pm_idx = 0; pm_asm = 0; pm_sum = 0;
							pm_phase = P_DATA;
						end
					end else start_skip(size);
				end
			end
			P_RIFF: begin
				pm_fcnt++;
				if (pm_fcnt >= 4) begin
					pm_fcnt = 0;
					pm_phase = P_HEADER;
				end
			end
			P_FMT: begin
				case (pm_fcnt)
					2:  pm_chans[7:0] = b;
					3:  pm_chans[15:8] = b;
					12: pm_align[7:0] = b;
					13: pm_align[15:8] = b;
					14: pm_bits[7:0] = b;
					15: pm_bits[15:8] = b;
					default: ;
				endcase
				pm_fcnt++;
				if (pm_fcnt >= 16) begin
					pm_fcnt = 0;
					start_skip(pm_left > 16 ? pm_left - 16 : 32'd0);
				end
			end
			P_SKIP: begin
				if (pm_left > 0) pm_left--;
				if (pm_left == 0) pm_phase = P_HEADER;
			end
			P_DATA: begin
				accumulate(b);
				if (pm_left > 0) pm_left--;
				pm_idx++;
				if (pm_idx >= pm_align) begin
					last = pm_left < pm_align;
					if (it.end_of_stream && !last) r.status = ST_EARLY;
					else r = mix_slice();
					mix_expected.push_back(r);
					pm_idx = 0; pm_asm = 0; pm_sum = 0;
					if (last) start_skip(pm_left);
				end else if (it.end_of_stream) begin
					r.status = ST_EARLY;
					mix_expected.push_back(r);
				end
			end
			default: pm_phase = P_HEADER;
		endcase
		if (it.end_of_stream) clear_parser();
	endfunction

	// send one byte, honoring the burst/gap pattern of the sender
	task automatic send_byte(logic [7:0] b, logic eos);
		in_item_t it;
		it.data_byte = b;
		it.end_of_stream = eos;
		while (gap_left > 0) begin
			gap_left--;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_byte(it);
		if (burst_left > 0) burst_left--;
		else begin
			burst_left = $urandom_range(0, 30);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		end
		if (gap_left > 0) in_valid <= 1'b0;
	endtask

	task automatic send_word(logic [31:0] w, int unsigned nbytes);
		for (int i = 0; i < nbytes; i++) send_byte(w[8*i +: 8], 1'b0);
	endtask

	task automatic send_riff();
		send_word(ID_RIFF, 4);
		send_word($urandom, 4);
		send_word(32'h45564157, 4);
	endtask

	task automatic send_fmt(logic [15:0] chans, logic [15:0] align, logic [15:0] bits,
			int unsigned extra);
		send_word(ID_FMT, 4);
		send_word(16 + extra, 4);
		send_word({chans, 16'd1}, 4);
		send_word($urandom, 4);
		send_word($urandom, 4);
		send_word({bits, align}, 4);
		for (int i = 0; i < extra; i++) send_byte(8'($urandom), 1'b0);
	endtask

	task automatic send_skipped(logic [31:0] id, int unsigned len);
		send_word(id, 4);
		send_word(len, 4);
		for (int i = 0; i < len; i++) send_byte(8'($urandom), 1'b0);
	endtask

	// data chunk; an eos_at from 0 to len-1 marks that byte as the end of the file
	task automatic send_data(int unsigned len, int eos_at, int bias);
		logic [7:0] b;
		send_word(ID_DATA, 4);
		send_word(len, 4);
		for (int i = 0; i < len; i++) begin
			case (bias)
				1: b = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
				2: b = (i % 2 == 0) ? 8'h00 : 8'h80;
				default: b = 8'($urandom);
			endcase
			send_byte(b, i == eos_at);
			if (i == eos_at) return;
		end
	endtask

	task automatic end_file();
		send_byte(8'($urandom), 1'b1);
	endtask

	// let the mixer drain before moving on
	task automatic drain();
		int guard;
		guard = 0;
		if (gap_left == 0) in_valid <= 1'b0;
		while (mix_expected.size() != 0 && guard < 20000) begin
			guard++;
			@(posedge clk);
		end
		repeat (60) @(posedge clk);
	endtask

	// check each result against the oldest prediction
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (mix_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transfer: dac=%h status=%0d",
						out_data.dac_sample, out_data.status);
			end else begin
				exp_r = mix_expected.pop_front();
				if (exp_r !== out_data) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp dac=%h st=%0d got dac=%h st=%0d",
							exp_r.dac_sample, exp_r.status,
							out_data.dac_sample, out_data.status);
				end
			end
		end
	end

	// receiver stall pattern: long ready stretches and bursts of stalls
	always @(posedge clk) begin
		int mode;
		mode = cycles / 3000 % 3;
		if (mode == 0) out_ready <= 1'b1;
		else if (mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
		else out_ready <= ($urandom_range(0, 1) != 0);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** wav_chunk_parser_mixdown: FAILED **");
			$finish;
		end
	end

	task automatic test_formats();
		// 8, 16 and 32 bit at extreme values, mono and max channels
		send_riff();
		send_fmt(16'd1, 16'd1, 16'd8, 0);
		send_data(4, -1, 1);
		send_fmt(16'd8, 16'd16, 16'd16, 2);
		send_data(48, -1, 2);
		send_fmt(16'd2, 16'd8, 16'd32, 0);
		send_data(24, -1, 1);
		end_file();
		drain();
	endtask

	task automatic test_special_cases();
		// data before fmt, unknown and LIST chunks, zero-size skip
		send_riff();
		send_data(6, -1, 0);
		send_skipped(ID_LIST, 5);
		send_skipped(32'hDEADBEEF, 0);
		// unsupported width, padded slices, leftover bytes, short chunk
		send_fmt(16'd2, 16'd3, 16'd24, 0);
		send_data(7, -1, 0);
		send_fmt(16'd3, 16'd5, 16'd16, 0);
		send_data(11, -1, 0);
		send_data(4, -1, 0);
		// bad channel counts
		send_fmt(16'd0, 16'd2, 16'd8, 0);
		send_data(4, -1, 0);
		send_fmt(16'hFFFF, 16'd2, 16'd16, 0);
		send_data(4, -1, 0);
		// early end mid slice
		send_fmt(16'd2, 16'd4, 16'd16, 0);
		send_data(16, 5, 0);
		drain();
		// early end on a slice boundary, and eos in header phase
		send_riff();
		send_fmt(16'd1, 16'd2, 16'd16, 0);
		send_data(8, 3, 0);
		send_byte(8'hFF, 1'b1);
		drain();
	endtask

	task automatic test_random_files();
		int chans, bits, align, len, pick, eos_at;
		int unsigned sent;
		sent = 0;
		while (sent < 1400) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				// raw noise bytes
				for (int i = 0; i < 20; i++)
					send_byte(8'($urandom), $urandom_range(0, 19) == 0);
				sent += 20;
			end else begin
				chans = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12)
					: $urandom_range(1, MAX_CH);
				case ($urandom_range(0, 3))
					0: bits = 8;
					1: bits = 16;
					2: bits = 32;
					default: bits = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : 16;
				endcase
				align = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12)
					: chans * ((bits == 8) ? 1 : (bits == 32) ? 4 : 2);
				if (align > 32) align = 32;
				send_riff();
				if ($urandom_range(0, 3) == 0) send_skipped(ID_LIST, $urandom_range(0, 6));
				send_fmt(16'(chans), 16'(align), 16'(bits),
					$urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : 0);
				len = $urandom_range(0, 6) * (align == 0 ? 1 : align) + $urandom_range(0, 2);
				eos_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len) : -1;
				send_data(len, eos_at, $urandom_range(0, 4));
				if (eos_at < 0 || eos_at >= len) end_file();
				sent += 45 + len;
			end
		end
		drain();
	endtask

	initial begin
		clear_parser();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_formats();
		test_special_cases();
		test_random_files();
		if (mismatches == 0 && mix_expected.size() == 0)
			$display("** wav_chunk_parser_mixdown: PASSED **");
		else
			$display("** wav_chunk_parser_mixdown: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire
